// ===== rtl/core/rtti_pkg.sv =====
// ----------------------------------------------------------------------------
// rtti_pkg
// Shared types and constants for the region to tile index unit.
// ----------------------------------------------------------------------------
package rtti_pkg;

	localparam int NDIM_MAX     = 3;
	localparam int DIMS_DEFAULT = 3;
	localparam int TILE_W       = 31;
	localparam int COORD_W      = 32;
	localparam int IDX_W        = 32;
	localparam int CFG_IDX_W    = 3;
	// divide steps in a lane, one quotient bit per stage
	localparam int DIV_BITS     = 31;
	// input capture, divide stages, check stage
	localparam int LANE_LAT     = DIV_BITS + 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TILE_0   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_0 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LAST     = 3'd5;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_ALIGN = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CFG_IDLE,
		CFG_LOAD,
		CFG_DIV
	} cfg_state_t;

	// geometry handed from the register block to the datapath
	typedef struct packed {
		logic [NDIM_MAX-1:0][TILE_W-1:0] tile;    // effective tile size, never 0
		logic [NDIM_MAX-1:0][TILE_W-1:0] extent;
		logic [NDIM_MAX-1:0][IDX_W-1:0]  tiles;   // tiles per dimension
	} geom_t;

endpackage

// ===== rtl/core/rtti_cfg.sv =====
// ----------------------------------------------------------------------------
// rtti_cfg
// Configuration registers and a sequential divider recomputing the tile
// count per dimension, ceil(extent / tile), after each tile or extent write.
// ----------------------------------------------------------------------------
module rtti_cfg
	import rtti_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TILE_W-1:0]    cfg_data,
	output geom_t                geom
);

	localparam logic [4:0] LAST_STEP = 5'(IDX_W - 1);

	cfg_state_t state_q, state_d;
	logic [NDIM_MAX-1:0][TILE_W-1:0] tile_q, ext_q, teff;
	logic [NDIM_MAX-1:0][IDX_W-1:0]  tiles_q;
	logic [1:0]        dim_q;
	logic [4:0]        cnt_q;
	logic [IDX_W-1:0]  num_q;
	logic [TILE_W-1:0] rem_q;
	logic [IDX_W-1:0]  trial;
	logic              ge;
	logic              wr;
	logic [1:0]        ext_sel;

	// zero tile size acts as one
	always_comb begin
		for (int d = 0; d < NDIM_MAX; d++) begin
			teff[d] = (tile_q[d] == '0) ? TILE_W'(1) : tile_q[d];
		end
	end

	assign cfg_ready = (state_q == CFG_IDLE);
	assign wr        = cfg_valid && cfg_ready;
	assign ext_sel   = 2'(cfg_index - REG_EXTENT_0);
	assign trial     = {rem_q, num_q[IDX_W-1]};
	assign ge        = trial >= {1'b0, teff[dim_q]};

	assign geom.tile   = teff;
	assign geom.extent = ext_q;
	assign geom.tiles  = tiles_q;

	// sequence the recompute: load a dividend, then one quotient bit a cycle
	always_comb begin
		state_d = state_q;
		case (state_q)
			CFG_IDLE: begin
				if (wr && cfg_index <= REG_LAST) state_d = CFG_LOAD;
			end
			CFG_LOAD: state_d = CFG_DIV;
			CFG_DIV: begin
				if (cnt_q == LAST_STEP)
					state_d = (dim_q == 2'(NDIM_MAX - 1)) ? CFG_IDLE : CFG_LOAD;
			end
			default: state_d = CFG_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CFG_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// hold registers, counters and results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < NDIM_MAX; d++) begin
				tile_q[d]  <= TILE_W'(1);
				ext_q[d]   <= '0;
				tiles_q[d] <= '0;
			end
			dim_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				if (cfg_index < REG_EXTENT_0) tile_q[cfg_index[1:0]] <= cfg_data;
				else if (cfg_index <= REG_LAST) ext_q[ext_sel] <= cfg_data;
			end
			if (state_q == CFG_LOAD) cnt_q <= '0;
			if (state_q == CFG_DIV) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == LAST_STEP) begin
					tiles_q[dim_q] <= {num_q[IDX_W-2:0], ge};
					dim_q <= (dim_q == 2'(NDIM_MAX - 1)) ? 2'd0 : dim_q + 2'd1;
				end
			end
		end
	end

	// divider datapath
	always_ff @(posedge clk) begin
		if (state_q == CFG_LOAD) begin
			num_q <= {1'b0, ext_q[dim_q]} + {1'b0, teff[dim_q]} - IDX_W'(1);
			rem_q <= '0;
		end else if (state_q == CFG_DIV) begin
			rem_q <= ge ? TILE_W'(trial - {1'b0, teff[dim_q]}) : trial[TILE_W-1:0];
			num_q <= {num_q[IDX_W-2:0], ge};
		end
	end

endmodule

// ===== rtl/core/rtti_lane.sv =====
// ----------------------------------------------------------------------------
// rtti_lane
// One dimension: pipelined restoring divider giving the tile coordinate
// floor(lo / tile), then the range and alignment checks.
// ----------------------------------------------------------------------------
module rtti_lane
	import rtti_pkg::*;
(
	input  logic               clk,
	input  logic               en,
	input  logic [COORD_W-1:0] lo,
	input  logic [COORD_W-1:0] hi,
	input  logic [TILE_W-1:0]  tile,
	input  logic [TILE_W-1:0]  extent,
	output logic [TILE_W-1:0]  coord,
	output status_t            err
);

	// stage j holds the state after j divide steps
	logic [TILE_W-1:0]  rem_s [DIV_BITS+1];
	logic [TILE_W-1:0]  qn_s  [DIV_BITS+1];
	logic [COORD_W-1:0] lo_s  [DIV_BITS+1];
	logic [COORD_W-1:0] hi_s  [DIV_BITS+1];
	logic [TILE_W-1:0]  coord_s;
	status_t            err_s;

	logic [TILE_W-1:0] rem_f, base_f;
	logic [IDX_W-1:0]  end_f;
	logic              range_f, align_f;

	// capture and divide, one quotient bit per stage
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= '0;
			qn_s[0]  <= lo[TILE_W-1:0];
			lo_s[0]  <= lo;
			hi_s[0]  <= hi;
			for (int j = 0; j < DIV_BITS; j++) begin
				logic [TILE_W:0] trial;
				logic            ge;
				trial = {rem_s[j], qn_s[j][TILE_W-1]};
				ge    = trial >= {1'b0, tile};
				rem_s[j+1] <= ge ? TILE_W'(trial - {1'b0, tile}) : trial[TILE_W-1:0];
				qn_s[j+1]  <= {qn_s[j][TILE_W-2:0], ge};
				lo_s[j+1]  <= lo_s[j];
				hi_s[j+1]  <= hi_s[j];
			end
		end
	end

	// k*tile = lo - rem; k < ceil(extent/tile) exactly when k*tile < extent
	assign rem_f   = rem_s[DIV_BITS];
	assign base_f  = lo_s[DIV_BITS][TILE_W-1:0] - rem_f;
	assign end_f   = {1'b0, base_f} + {1'b0, tile};
	assign range_f = lo_s[DIV_BITS][COORD_W-1] || (base_f >= extent);
	assign align_f = !hi_s[DIV_BITS][COORD_W-1]
		&& ({1'b0, hi_s[DIV_BITS][COORD_W-2:0]} > end_f);

	always_ff @(posedge clk) begin
		if (en) begin
			coord_s <= qn_s[DIV_BITS];
			err_s   <= range_f ? ST_RANGE : (align_f ? ST_ALIGN : ST_OK);
		end
	end

	assign coord = coord_s;
	assign err   = err_s;

endmodule

// ===== rtl/core/rtti_combine.sv =====
// ----------------------------------------------------------------------------
// rtti_combine
// Picks the first failing dimension and folds the tile coordinates into the
// row-major index over three stages, a multiply in each of the first two.
// ----------------------------------------------------------------------------
module rtti_combine
	import rtti_pkg::*;
#(
	parameter int DIMS = DIMS_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             valid_in,
	input  logic [NDIM_MAX-1:0][TILE_W-1:0]  coord,
	input  status_t [NDIM_MAX-1:0]           err,
	input  logic [NDIM_MAX-1:0][IDX_W-1:0]   tiles,
	output logic                             valid_out,
	output logic [IDX_W-1:0]                 tile_index,
	output status_t                          status,
	output logic [1:0]                       bad_dim
);

	logic [NDIM_MAX-1:0][IDX_W-1:0] k_e, n_e;
	status_t    st_f;
	logic [1:0] bd_f;

	logic v_s1, v_s2, v_s3;
	logic [IDX_W-1:0] p_s1, k1_s1, k2_s1, p_s2, k2_s2, idx_s3;
	status_t    st_s1, st_s2, st_s3;
	logic [1:0] bd_s1, bd_s2, bd_s3;

	// unused dimensions contribute nothing
	always_comb begin
		for (int d = 0; d < NDIM_MAX; d++) begin
			k_e[d] = (d < DIMS) ? {1'b0, coord[d]} : '0;
			n_e[d] = (d < DIMS) ? tiles[d] : IDX_W'(1);
		end
	end

	// first failing dimension wins
	always_comb begin
		st_f = ST_OK;
		bd_f = '0;
		for (int d = DIMS - 1; d >= 0; d--) begin
			if (err[d] != ST_OK) begin
				st_f = err[d];
				bd_f = 2'(d);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// advance the index fold
	always_ff @(posedge clk) begin
		if (en) begin
			p_s1   <= IDX_W'(k_e[0] * n_e[1]);
			k1_s1  <= k_e[1];
			k2_s1  <= k_e[2];
			st_s1  <= st_f;
			bd_s1  <= bd_f;
			p_s2   <= IDX_W'((p_s1 + k1_s1) * n_e[2]);
			k2_s2  <= k2_s1;
			st_s2  <= st_s1;
			bd_s2  <= bd_s1;
			idx_s3 <= (st_s2 == ST_OK) ? p_s2 + k2_s2 : '0;
			st_s3  <= st_s2;
			bd_s3  <= bd_s2;
		end
	end

	assign valid_out  = v_s3;
	assign tile_index = idx_s3;
	assign status     = st_s3;
	assign bad_dim    = bd_s3;

endmodule

// ===== rtl/core/region_to_tile_index_unit.sv =====
// ----------------------------------------------------------------------------
// region_to_tile_index_unit
// Maps a 3-D region to the row-major index of the tile that holds it, with
// out-of-range and misaligned-region reporting.
//
//   channel  direction  handshake           payload
//   in       sink       in_valid/in_stall   lo_0 hi_0 lo_1 hi_1 lo_2 hi_2
//   out      source     out_valid/out_stall tile_index status bad_dim
//   cfg      sink       cfg_valid/cfg_ready cfg_index cfg_data
//
// One region per cycle when not stalled, through capture, the 31 divide
// stages of each lane, a check stage and three fold stages. A tile or extent
// register write starts a recompute of the tile counts, during which
// in_stall and !cfg_ready hold. out_stall on a valid result freezes the whole
// pipeline. Reset clears all valid bits and loads tile sizes 1, extents 0.
// ----------------------------------------------------------------------------
module region_to_tile_index_unit
	import rtti_pkg::*;
#(
	parameter int DIMS = DIMS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [COORD_W-1:0]   lo_0,
	input  logic [COORD_W-1:0]   hi_0,
	input  logic [COORD_W-1:0]   lo_1,
	input  logic [COORD_W-1:0]   hi_1,
	input  logic [COORD_W-1:0]   lo_2,
	input  logic [COORD_W-1:0]   hi_2,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [IDX_W-1:0]     tile_index,
	output logic [1:0]           status,
	output logic [1:0]           bad_dim,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TILE_W-1:0]    cfg_data
);

	geom_t geom;
	logic  en;
	logic [LANE_LAT-1:0] v_s;
	logic [NDIM_MAX-1:0][COORD_W-1:0] lo_v, hi_v;
	logic [NDIM_MAX-1:0][TILE_W-1:0]  coord;
	status_t [NDIM_MAX-1:0]           err;
	status_t                          status_w;

	assign lo_v = {lo_2, lo_1, lo_0};
	assign hi_v = {hi_2, hi_1, hi_0};

	// advance whenever the output register is free or being taken
	assign en       = !out_valid || !out_stall;
	assign in_stall = !en || !cfg_ready;

	rtti_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom)
	);

	for (genvar d = 0; d < NDIM_MAX; d++) begin : g_lane
		rtti_lane u_lane (
			.clk    (clk),
			.en     (en),
			.lo     (lo_v[d]),
			.hi     (hi_v[d]),
			.tile   (geom.tile[d]),
			.extent (geom.extent[d]),
			.coord  (coord[d]),
			.err    (err[d])
		);
	end

	// valid bits alongside the lane stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[LANE_LAT-2:0], in_valid && cfg_ready};
		end
	end

	rtti_combine #(
		.DIMS (DIMS)
	) u_combine (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.valid_in   (v_s[LANE_LAT-1]),
		.coord      (coord),
		.err        (err),
		.tiles      (geom.tiles),
		.valid_out  (out_valid),
		.tile_index (tile_index),
		.status     (status_w),
		.bad_dim    (bad_dim)
	);

	assign status = status_w;

	// no region enters while tile counts are being recomputed
	a_cfg_block: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_ready |-> in_stall)
		else $error("region accepted during recompute");

	// a good result reports no failing dimension
	a_ok_dim: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |-> bad_dim == 2'd0)
		else $error("bad_dim set on good result");

	// a failed result carries index zero
	a_err_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> tile_index == '0)
		else $error("index set on failed result");

	// a write to a tile or extent register always starts a recompute
	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && cfg_index <= REG_LAST |=> !cfg_ready)
		else $error("write did not start recompute");

endmodule

// ===== test/region_to_tile_index_unit_test.sv =====
// ----------------------------------------------------------------------------
// region_to_tile_index_unit_test
// Drives regions through the tile index unit under several array geometries.
// Each result is checked against an in-bench model of the tile mapping.
// Both channels idle at random, and the configuration is rewritten between
// phases.
// ----------------------------------------------------------------------------
module region_to_tile_index_unit_test;
	import rtti_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [1:0]       st;
		logic [1:0]       dim;
	} tile_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic out_stall = 1'b0;
	logic cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [TILE_W-1:0] cfg_data = '0;
	logic [COORD_W-1:0] lo_0 = '0, hi_0 = '0, lo_1 = '0, hi_1 = '0, lo_2 = '0, hi_2 = '0;
	logic in_stall, out_valid, cfg_ready;
	logic [IDX_W-1:0] tile_index;
	logic [1:0] status, bad_dim;

	region_to_tile_index_unit dut (.*);

	// model geometry
	logic [31:0] tile_sz [3];
	logic [31:0] ext [3];
	logic [31:0] tiles [3];

	tile_result_t pending_results [$];
	int errors = 0;
	int results_seen = 0;
	int items_sent = 0;
	int cycles = 0;
	bit calm = 0;

	initial forever #2 clk = ~clk;

	// stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILURE");
			$finish;
		end
	end

	// randomly stall the result side
	always @(posedge clk) begin
		out_stall <= calm ? 1'b0 : ($urandom_range(99) < 33);
	end

	function automatic void recount();
		logic [63:0] t;
		for (int d = 0; d < 3; d++) begin
			t = (tile_sz[d] == 0) ? 64'd1 : 64'(tile_sz[d]);
			tiles[d] = 32'((64'(ext[d]) + t - 1) / t);
		end
	endfunction

	function automatic tile_result_t map_region(logic [31:0] lo[3], logic [31:0] hi[3]);
		tile_result_t r;
		logic [31:0] acc;
		longint l, h, t, k;
		acc = 0;
		for (int d = 0; d < 3; d++) begin
			l = longint'($signed(lo[d]));
			h = longint'($signed(hi[d]));
			t = (tile_sz[d] == 0) ? 1 : longint'(tile_sz[d]);
			k = l / t;
			if ((l % t) != 0 && l < 0) k = k - 1;
			if (k < 0 || k >= longint'(tiles[d])) begin
				r.idx = 0; r.st = ST_RANGE; r.dim = 2'(d);
				return r;
			end
			if (h > (k + 1) * t) begin
				r.idx = 0; r.st = ST_ALIGN; r.dim = 2'(d);
				return r;
			end
			acc = acc * tiles[d] + 32'(k);
		end
		r.idx = acc; r.st = ST_OK; r.dim = 0;
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, results_seen);
		errors++;
	endtask

	// compare each result transfer with the oldest prediction
	always @(posedge clk) begin
		tile_result_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report("unexpected", tile_index, 0);
			end else begin
				w = pending_results.pop_front();
				if (tile_index !== w.idx) report("tile_index", tile_index, w.idx);
				if (status !== w.st) report("status", 32'(status), 32'(w.st));
				if (bad_dim !== w.dim) report("bad_dim", 32'(bad_dim), 32'(w.dim));
			end
			results_seen++;
		end
	end

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] i, logic [TILE_W-1:0] v);
		cfg_valid <= 1'b1; cfg_index <= i; cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (i <= REG_LAST) begin
			if (i < REG_EXTENT_0) tile_sz[i] = 32'(v);
			else ext[i - REG_EXTENT_0] = 32'(v);
			recount();
		end
		// hold off while tile counts recompute
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_geometry(logic [30:0] t0, t1, t2, e0, e1, e2);
		drain();
		write_reg(REG_TILE_0, t0); write_reg(3'(REG_TILE_0 + 1), t1);
		write_reg(3'(REG_TILE_0 + 2), t2); write_reg(REG_EXTENT_0, e0);
		write_reg(3'(REG_EXTENT_0 + 1), e1); write_reg(3'(REG_EXTENT_0 + 2), e2);
	endtask

	// drop valid only while idling, so back-to-back transfers keep it high
	task automatic send_region(logic [31:0] lo[3], logic [31:0] hi[3]);
		while (!calm && $urandom_range(99) < 33) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		lo_0 <= lo[0]; hi_0 <= hi[0]; lo_1 <= lo[1];
		hi_1 <= hi[1]; lo_2 <= lo[2]; hi_2 <= hi[2];
		do @(posedge clk); while (in_stall);
		pending_results.push_back(map_region(lo, hi));
		items_sent++;
	endtask

	// a region inside one tile, random tile, sometimes off by a little
	task automatic send_random(int noise);
		logic [31:0] lo[3], hi[3];
		longint t, k, n;
		for (int d = 0; d < 3; d++) begin
			t = (tile_sz[d] == 0) ? 1 : longint'(tile_sz[d]);
			n = longint'(tiles[d]);
			if (($urandom_range(99) < noise) || n == 0) begin
				lo[d] = $urandom(); hi[d] = $urandom();
			end else begin
				k = (n > 1) ? longint'($urandom_range(32'(n - 1))) : 0;
				lo[d] = 32'(k * t + ((t > 1) ? longint'($urandom_range(32'(t - 1))) : 0));
				hi[d] = 32'(k * t + t - longint'($urandom_range(1)));
				if ($urandom_range(19) == 0) hi[d] = hi[d] + 1;
				if ($urandom_range(29) == 0) lo[d] = 32'(-longint'($urandom_range(3)) - 1);
			end
		end
		send_region(lo, hi);
	endtask

	task automatic test_reset_geometry();
		logic [31:0] lo[3] = '{0, 0, 0}, hi[3] = '{1, 1, 1};
		send_region(lo, hi);
	endtask

	task automatic test_directed();
		logic [31:0] lo[3], hi[3];
		set_geometry(4, 3, 5, 10, 9, 23);
		lo = '{0, 0, 0}; hi = '{4, 3, 5}; send_region(lo, hi);
		lo = '{8, 6, 20}; hi = '{10, 9, 25}; send_region(lo, hi);
		lo = '{12, 0, 0}; hi = '{12, 0, 0}; send_region(lo, hi);
		lo = '{0, 9, 0}; hi = '{0, 9, 0}; send_region(lo, hi);
		lo = '{0, 0, 25}; hi = '{0, 0, 0}; send_region(lo, hi);
		lo = '{32'hFFFFFFFF, 0, 0}; hi = '{0, 0, 0}; send_region(lo, hi);
		lo = '{32'h80000000, 0, 0}; hi = '{32'h7FFFFFFF, 0, 0}; send_region(lo, hi);
		lo = '{0, 0, 0}; hi = '{5, 0, 0}; send_region(lo, hi);
		lo = '{0, 3, 0}; hi = '{0, 7, 0}; send_region(lo, hi);
		lo = '{0, 0, 5}; hi = '{0, 0, 11}; send_region(lo, hi);
		lo = '{4, 3, 5}; hi = '{2, 32'h80000000, 1}; send_region(lo, hi);
		lo = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF};
		hi = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF}; send_region(lo, hi);
		// zero tile size acts as one, out-of-range register ignored
		set_geometry(0, 0, 0, 3, 3, 3);
		write_reg(3'd6, 31'h7FFFFFFF); write_reg(3'd7, 31'd5);
		lo = '{2, 1, 0}; hi = '{3, 2, 1}; send_region(lo, hi);
		lo = '{2, 1, 3}; hi = '{3, 2, 4}; send_region(lo, hi);
		// largest sizes and extents
		set_geometry(31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF,
			31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF);
		lo = '{0, 32'h7FFFFFFE, 0}; hi = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000};
		send_region(lo, hi);
		lo = '{0, 0, 0}; hi = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF};
		send_region(lo, hi);
		set_geometry(1, 1, 1, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF);
		lo = '{32'h7FFFFFFE, 32'h7FFFFFFE, 32'h7FFFFFFE};
		hi = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF}; send_region(lo, hi);
	endtask

	task automatic test_random_phase(int n, int noise);
		logic [30:0] v[6];
		for (int d = 0; d < 3; d++) begin
			v[d] = 31'($urandom_range(1, 40));
			if ($urandom_range(7) == 0) v[d] = 0;
			v[d + 3] = 31'($urandom_range(0, 200));
		end
		if ($urandom_range(3) == 0) begin
			v[0] = 31'($urandom()); v[3] = 31'($urandom());
		end
		set_geometry(v[0], v[1], v[2], v[3], v[4], v[5]);
		for (int i = 0; i < n; i++) send_random(noise);
	endtask

	initial begin
		tile_sz = '{1, 1, 1}; ext = '{0, 0, 0}; recount();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_geometry();
		test_directed();
		for (int p = 0; p < 8; p++) test_random_phase(110, 15);
		calm = 1;
		test_random_phase(150, 10);
		calm = 0;
		test_random_phase(30, 90);
		drain();
		$display("sent %0d regions over directed and random geometries,", items_sent);
		$display("checked %0d results with random stalls on both sides", results_seen);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
